### rtl/mrlt_pkg.sv
// Shared types, codes and constants for the memory range lease table.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mrlt_pkg;

    localparam int LEASE_SLOTS_DEF = 16;

    localparam int ID_W    = 64;
    localparam int START_W = 40;
    localparam int LEN_W   = 41;
    localparam int END_W   = 42;
    localparam int CMD_W   = 2;
    localparam int STAT_W  = 3;

    localparam logic [LEN_W-1:0] REGION_RESET = 41'd1048576;

    localparam logic [CMD_W-1:0] CMD_ACQUIRE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_LOOKUP  = 2'd2;

    localparam logic [STAT_W-1:0] STAT_OK        = 3'd0;
    localparam logic [STAT_W-1:0] STAT_INVALID   = 3'd1;
    localparam logic [STAT_W-1:0] STAT_CONFLICT  = 3'd2;
    localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 3'd3;
    localparam logic [STAT_W-1:0] STAT_FULL      = 3'd4;

    // request held stable by the controller for the whole scan
    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [ID_W-1:0]    id;
        logic [START_W-1:0] start;
        logic [END_W-1:0]   stop;
    } req_t;

    // scan token handed from cell to cell
    typedef struct packed {
        logic valid;
        logic same;
        logic clash;
        logic hit;
        logic free;
    } tok_t;

endpackage

`default_nettype wire

### rtl/memory_range_lease_table_top.sv
// The scan token walks the cell chain one slot a cycle; an invalid request
// skips the scan and goes from the check straight to the decision. One request
// in flight at a time: the input stalls until the result is issued, and a
// waiting result does not block the next input. Reset (async, active low)
// empties every slot at once and sets region_reg to 1 MiB.
`timescale 1ns / 1ps
`default_nettype none

module memory_range_lease_table_top #(
    parameter int LEASE_SLOTS = mrlt_pkg::LEASE_SLOTS_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_stall,
    input  wire logic [mrlt_pkg::CMD_W-1:0]   cmd,
    input  wire logic [mrlt_pkg::ID_W-1:0]    owner_id,
    input  wire logic [mrlt_pkg::START_W-1:0] range_start,
    input  wire logic [mrlt_pkg::LEN_W-1:0]   range_length,
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output logic [mrlt_pkg::STAT_W-1:0]       status,
    input  wire logic                         cfg_wr_en,
    input  wire logic [mrlt_pkg::LEN_W-1:0]   cfg_wr_data
);

    logic [mrlt_pkg::LEN_W-1:0] region_reg;
    mrlt_pkg::req_t             req;
    mrlt_pkg::tok_t             tok [LEASE_SLOTS+1];
    logic                       commit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            region_reg <= mrlt_pkg::REGION_RESET;
        else if (cfg_wr_en)
            region_reg <= cfg_wr_data;
    end

    mrlt_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .cmd          (cmd),
        .owner_id     (owner_id),
        .range_start  (range_start),
        .range_length (range_length),
        .region       (region_reg),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .req          (req),
        .tok_first    (tok[0]),
        .tok_last     (tok[LEASE_SLOTS]),
        .commit       (commit)
    );

    for (genvar i = 0; i < LEASE_SLOTS; i++)
    begin : g_cell
        mrlt_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .req     (req),
            .commit  (commit),
            .tok_in  (tok[i]),
            .tok_out (tok[i+1])
        );
    end

endmodule

`default_nettype wire

### rtl/mrlt_cell.sv
// One lease slot of the chain: holds a lease, checks the passing token.
// Depends on mrlt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mrlt_cell (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire mrlt_pkg::req_t req,
    input  wire logic          commit,
    input  wire mrlt_pkg::tok_t tok_in,
    output mrlt_pkg::tok_t     tok_out
);

    logic                         valid_reg, valid_next;
    logic                         claim_reg, claim_next;
    logic [mrlt_pkg::ID_W-1:0]    id_reg;
    logic [mrlt_pkg::START_W-1:0] start_reg;
    logic [mrlt_pkg::END_W-1:0]   end_reg;
    mrlt_pkg::tok_t               tok_reg, tok_next;

    logic id_eq, match, same_here, clash_here, overlap, is_acq, is_rel;

    always_comb
    begin
        is_acq     = (req.cmd == mrlt_pkg::CMD_ACQUIRE);
        is_rel     = (req.cmd == mrlt_pkg::CMD_RELEASE);
        id_eq      = (id_reg == req.id);
        match      = valid_reg && id_eq;
        overlap    = !((req.stop <= {2'b00, start_reg}) ||
                       (end_reg <= {2'b00, req.start}));
        same_here  = is_acq && match && (start_reg == req.start) &&
                     (end_reg == req.stop);
        clash_here = is_acq && valid_reg && !id_eq && overlap;

        tok_next       = tok_in;
        tok_next.same  = tok_in.same  | same_here;
        tok_next.clash = tok_in.clash | clash_here;
        tok_next.hit   = tok_in.hit   | match;
        tok_next.free  = tok_in.free  | !valid_reg;

        valid_next = valid_reg;
        claim_next = claim_reg;
        if (tok_in.valid)
        begin
            claim_next = !valid_reg && !tok_in.free;
            if (is_rel && match)
                valid_next = 1'b0;
        end
        if (commit && claim_reg)
            valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            claim_reg <= 1'b0;
            tok_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            claim_reg <= claim_next;
            tok_reg   <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (commit && claim_reg)
        begin
            id_reg    <= req.id;
            start_reg <= req.start;
            end_reg   <= req.stop;
        end
    end

    assign tok_out = tok_reg;

endmodule

`default_nettype wire

### rtl/mrlt_ctrl.sv
// Request sequencer: takes a transfer, validates it, runs the scan token
// through the cell chain, decides status and commits inserts. Uses mrlt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mrlt_ctrl (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_stall,
    input  wire logic [mrlt_pkg::CMD_W-1:0]   cmd,
    input  wire logic [mrlt_pkg::ID_W-1:0]    owner_id,
    input  wire logic [mrlt_pkg::START_W-1:0] range_start,
    input  wire logic [mrlt_pkg::LEN_W-1:0]   range_length,
    input  wire logic [mrlt_pkg::LEN_W-1:0]   region,
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output logic [mrlt_pkg::STAT_W-1:0]       status,
    output mrlt_pkg::req_t                    req,
    output mrlt_pkg::tok_t                    tok_first,
    input  wire mrlt_pkg::tok_t               tok_last,
    output logic                              commit
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_CHECK  = 3'd1;
    localparam logic [2:0] S_START  = 3'd2;
    localparam logic [2:0] S_SCAN   = 3'd3;
    localparam logic [2:0] S_DECIDE = 3'd4;

    logic [2:0]                     state_reg, state_next;
    logic [mrlt_pkg::CMD_W-1:0]     cmd_reg;
    logic [mrlt_pkg::ID_W-1:0]      id_reg;
    logic [mrlt_pkg::START_W-1:0]   start_reg;
    logic [mrlt_pkg::LEN_W-1:0]     len_reg;
    logic [mrlt_pkg::END_W-1:0]     end_reg;
    logic                           bad_reg, bad_next;
    mrlt_pkg::tok_t                 flags_reg;
    logic                           out_valid_reg, out_valid_next;
    logic [mrlt_pkg::STAT_W-1:0]    status_reg, status_next;

    logic                           accept, out_free, bad_now, do_commit;
    logic [mrlt_pkg::LEN_W-1:0]     start_ext;
    logic [mrlt_pkg::STAT_W-1:0]    verdict;

    always_comb
    begin
        accept    = in_valid && (state_reg == S_IDLE);
        out_free  = !out_valid_reg || !out_stall;
        start_ext = {1'b0, start_reg};

        bad_now = (id_reg == '0);
        unique case (cmd_reg)
            mrlt_pkg::CMD_ACQUIRE:
                bad_now = bad_now || (len_reg == '0) || (start_ext > region) ||
                          (len_reg > (region - start_ext));
            mrlt_pkg::CMD_RELEASE,
            mrlt_pkg::CMD_LOOKUP: ;
            default:
                bad_now = 1'b1;
        endcase

        do_commit = 1'b0;
        verdict   = mrlt_pkg::STAT_INVALID;
        if (!bad_reg)
        begin
            if (cmd_reg == mrlt_pkg::CMD_ACQUIRE)
            begin
                priority if (flags_reg.same)
                    verdict = mrlt_pkg::STAT_OK;
                else if (flags_reg.clash)
                    verdict = mrlt_pkg::STAT_CONFLICT;
                else if (!flags_reg.free)
                    verdict = mrlt_pkg::STAT_FULL;
                else
                begin
                    verdict   = mrlt_pkg::STAT_OK;
                    do_commit = 1'b1;
                end
            end
            else
                verdict = flags_reg.hit ? mrlt_pkg::STAT_OK : mrlt_pkg::STAT_NOT_FOUND;
        end

        state_next     = state_reg;
        bad_next       = bad_reg;
        out_valid_next = out_valid_reg && out_stall;
        status_next    = status_reg;
        commit         = 1'b0;
        unique case (state_reg)
            S_IDLE:
                if (in_valid)
                    state_next = S_CHECK;
            S_CHECK:
            begin
                bad_next   = bad_now;
                state_next = bad_now ? S_DECIDE : S_START;
            end
            S_START:
                state_next = S_SCAN;
            S_SCAN:
                if (tok_last.valid)
                    state_next = S_DECIDE;
            S_DECIDE:
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    status_next    = verdict;
                    commit         = do_commit;
                    state_next     = S_IDLE;
                end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            bad_reg       <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            bad_reg       <= bad_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg   <= cmd;
            id_reg    <= owner_id;
            start_reg <= range_start;
            len_reg   <= range_length;
        end
        if (state_reg == S_CHECK)
            end_reg <= {2'b00, start_reg} + {1'b0, len_reg};
        if ((state_reg == S_SCAN) && tok_last.valid)
            flags_reg <= tok_last;
        status_reg <= status_next;
    end

    always_comb
    begin
        req.cmd   = cmd_reg;
        req.id    = id_reg;
        req.start = start_reg;
        req.stop  = end_reg;

        tok_first       = '0;
        tok_first.valid = (state_reg == S_START);
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign status    = status_reg;

endmodule

`default_nettype wire

### rtl/mrlt_checker.sv
// Port-level checks for memory_range_lease_table_top, attached by bind.
// Depends on mrlt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mrlt_checker (
    input wire logic                        clk,
    input wire logic                        rst_n,
    input wire logic                        in_valid,
    input wire logic                        in_stall,
    input wire logic                        out_valid,
    input wire logic                        out_stall,
    input wire logic [mrlt_pkg::STAT_W-1:0] status
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status))
        else $error("stalled result changed");

    // one request at a time: a transfer in closes the input
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input open right after a transfer");

    // a new result only appears at the end of a request in flight
    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result without a request in flight");

endmodule

bind memory_range_lease_table_top mrlt_checker u_mrlt_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status)
);

`default_nettype wire

### sim/tb_top.sv
// Self-checking testbench for memory_range_lease_table_top: a directed table,
// then random lease traffic over several region sizes, each status checked
// against an in-bench model of the lease table. Needs rtl/mrlt_pkg.sv and the DUT.
`timescale 1ns / 1ps

module tb_top;

    import mrlt_pkg::*;

    localparam int SLOTS          = 16;
    localparam int POOL_N         = 20;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 48;
    localparam int DIR_ROWS       = 24;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam logic [LEN_W-1:0] REGION_MIN = 41'd1048576;
    localparam logic [LEN_W-1:0] REGION_MAX = 41'h100_0000_0000;
    localparam logic [ID_W-1:0]  ID_MAX     = '1;

    typedef struct {
        logic [CMD_W-1:0]   cmd;
        logic [ID_W-1:0]    id;
        logic [START_W-1:0] start;
        logic [LEN_W-1:0]   len;
        bit                 typed;
        logic [STAT_W-1:0]  st;
    } lease_req_t;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    logic [CMD_W-1:0]     cmd;
    logic [ID_W-1:0]      owner_id;
    logic [START_W-1:0]   range_start;
    logic [LEN_W-1:0]     range_length;
    logic                 out_valid;
    logic                 out_stall;
    logic [STAT_W-1:0]    status;
    logic                 cfg_wr_en;
    logic [LEN_W-1:0]     cfg_wr_data;

    // model of the lease table
    logic [LEN_W-1:0]     region_cfg;
    bit                   lt_valid [SLOTS];
    logic [ID_W-1:0]      lt_id    [SLOTS];
    logic [START_W-1:0]   lt_start [SLOTS];
    logic [LEN_W-1:0]     lt_len   [SLOTS];

    logic [STAT_W-1:0]    expected_status_q [$];
    logic [STAT_W-1:0]    exp_st;
    logic [ID_W-1:0]      id_pool [POOL_N];
    lease_req_t           dir_tab [DIR_ROWS];

    int send_idle;
    int recv_idle;
    int fail_count;
    int results_checked;
    int items_sent;
    int idle_cycles;
    int stat_tally [5];

    memory_range_lease_table_top u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .cmd          (cmd),
        .owner_id     (owner_id),
        .range_start  (range_start),
        .range_length (range_length),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    function automatic logic [STAT_W-1:0] lease_table_apply(
        input logic [CMD_W-1:0]   c,
        input logic [ID_W-1:0]    id,
        input logic [START_W-1:0] s,
        input logic [LEN_W-1:0]   l
    );
        logic [END_W-1:0] req_end;
        logic [END_W-1:0] slot_end;
        int               free_idx;
        bit               same;
        bit               clash;
        bit               hit;
        free_idx = -1;
        same     = 1'b0;
        clash    = 1'b0;
        hit      = 1'b0;
        if (id == '0 || c == CMD_UNUSED)
            return STAT_INVALID;
        case (c)
            CMD_ACQUIRE:
            begin
                if (l == '0)
                    return STAT_INVALID;
                if ({2'b0, s} > {1'b0, region_cfg} ||
                    {1'b0, l} > {1'b0, region_cfg} - {2'b0, s})
                    return STAT_INVALID;
                req_end = {2'b0, s} + {1'b0, l};
                for (int i = 0; i < SLOTS; i++)
                begin
                    slot_end = {2'b0, lt_start[i]} + {1'b0, lt_len[i]};
                    if (!lt_valid[i])
                    begin
                        if (free_idx < 0)
                            free_idx = i;
                    end
                    else if (lt_id[i] == id && lt_start[i] == s && lt_len[i] == l)
                        same = 1'b1;
                    else if (lt_id[i] != id &&
                             !(req_end <= {2'b0, lt_start[i]} || slot_end <= {2'b0, s}))
                        clash = 1'b1;
                end
                if (same)
                    return STAT_OK;
                if (clash)
                    return STAT_CONFLICT;
                if (free_idx < 0)
                    return STAT_FULL;
                lt_valid[free_idx] = 1'b1;
                lt_id[free_idx]    = id;
                lt_start[free_idx] = s;
                lt_len[free_idx]   = l;
                return STAT_OK;
            end
            CMD_RELEASE:
            begin
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (lt_valid[i] && lt_id[i] == id)
                    begin
                        lt_valid[i] = 1'b0;
                        hit = 1'b1;
                    end
                end
                return hit ? STAT_OK : STAT_NOT_FOUND;
            end
            default:
            begin
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (lt_valid[i] && lt_id[i] == id)
                        return STAT_OK;
                end
                return STAT_NOT_FOUND;
            end
        endcase
    endfunction

    function automatic lease_req_t req_row(
        input logic [CMD_W-1:0]   c,
        input logic [ID_W-1:0]    id,
        input logic [START_W-1:0] s,
        input logic [LEN_W-1:0]   l,
        input bit                 typed,
        input logic [STAT_W-1:0]  st
    );
        lease_req_t r;
        r.cmd   = c;
        r.id    = id;
        r.start = s;
        r.len   = l;
        r.typed = typed;
        r.st    = st;
        return r;
    endfunction

    task automatic send_req(input lease_req_t r);
        logic [STAT_W-1:0] pred;
        @(negedge clk);
        while ($urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        cmd          <= r.cmd;
        owner_id     <= r.id;
        range_start  <= r.start;
        range_length <= r.len;
        in_valid     <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        pred = lease_table_apply(r.cmd, r.id, r.start, r.len);
        if (r.typed)
            pred = r.st;
        expected_status_q.push_back(pred);
        if (pred < 5)
            stat_tally[pred]++;
        items_sent++;
    endtask

    task automatic make_rand_req(output lease_req_t r);
        logic [63:0]      rnd_a;
        logic [63:0]      rnd_b;
        logic [END_W-1:0] unit;
        logic [END_W-1:0] tmp;
        int               pick;
        int               idx;
        rnd_a   = {$urandom, $urandom};
        rnd_b   = {$urandom, $urandom};
        r.typed = 1'b0;
        r.st    = STAT_OK;
        r.start = rnd_a[START_W-1:0];
        r.len   = rnd_b[LEN_W-1:0];
        pick = $urandom_range(99);
        if (pick < 85)
            r.id = id_pool[$urandom_range(POOL_N - 1)];
        else if (pick < 95)
            r.id = {$urandom, $urandom};
        else
            r.id = '0;
        pick = $urandom_range(99);
        if (pick < 55)
            r.cmd = CMD_ACQUIRE;
        else if (pick < 70)
            r.cmd = CMD_RELEASE;
        else if (pick < 95)
            r.cmd = CMD_LOOKUP;
        else
            r.cmd = CMD_UNUSED;
        if (r.cmd == CMD_ACQUIRE)
        begin
            unit = {1'b0, region_cfg} >> 6;
            pick = $urandom_range(99);
            if (pick < 12)
            begin
                idx = $urandom_range(SLOTS - 1);
                if (lt_valid[idx])
                begin
                    r.id    = lt_id[idx];
                    r.start = lt_start[idx];
                    r.len   = lt_len[idx];
                end
            end
            else if (pick < 82)
            begin
                tmp     = unit * END_W'($urandom_range(63)) + END_W'($urandom_range(3));
                r.start = tmp[START_W-1:0];
                tmp     = unit * END_W'($urandom_range(1, 2)) - END_W'($urandom_range(3));
                r.len   = tmp[LEN_W-1:0];
            end
            else if (pick < 92)
            begin
                if ($urandom_range(1) == 1)
                    r.len = LEN_W'($urandom_range(1, 4096));
            end
            else
            begin
                // ranges that end at or just past the top of the region
                r.len   = LEN_W'($urandom_range(16));
                tmp     = {1'b0, region_cfg} - {1'b0, r.len} +
                          END_W'($urandom_range(1));
                r.start = tmp[START_W-1:0];
            end
        end
    endtask

    task automatic run_random(input int n);
        lease_req_t r;
        repeat (n)
        begin
            make_rand_req(r);
            send_req(r);
        end
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    task automatic set_region(input logic [LEN_W-1:0] v);
        while (expected_status_q.size() != 0)
            @(posedge clk);
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        region_cfg   = v;
    endtask

    always @(negedge clk)
        out_stall <= ($urandom_range(99) < recv_idle);

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_status_q.size() == 0)
            begin
                if (fail_count < 10)
                    $display("unexpected status transfer: got %0d", status);
                fail_count++;
            end
            else
            begin
                exp_st = expected_status_q.pop_front();
                results_checked++;
                if (status !== exp_st)
                begin
                    if (fail_count < 10)
                        $display("status mismatch: expected %0d, actual %0d", exp_st, status);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    initial
    begin
        logic [63:0] mid;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        cmd          = CMD_ACQUIRE;
        owner_id     = '0;
        range_start  = '0;
        range_length = '0;
        out_stall    = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_wr_data  = '0;
        send_idle    = 15;
        recv_idle    = 72;
        fail_count   = 0;
        results_checked = 0;
        items_sent   = 0;
        idle_cycles  = 0;
        region_cfg   = REGION_RESET;
        foreach (stat_tally[i])
            stat_tally[i] = 0;
        foreach (lt_valid[i])
        begin
            lt_valid[i] = 1'b0;
            lt_id[i]    = '0;
            lt_start[i] = '0;
            lt_len[i]   = '0;
        end
        id_pool[0] = ID_MAX;
        id_pool[1] = 64'd1;
        for (int i = 2; i < POOL_N; i++)
            id_pool[i] = {$urandom, $urandom} | 64'd1;

        dir_tab[0]  = req_row(CMD_LOOKUP,  64'd5, '0, '0, 1'b1, STAT_NOT_FOUND);
        dir_tab[1]  = req_row(CMD_RELEASE, 64'd5, '0, '0, 1'b1, STAT_NOT_FOUND);
        dir_tab[2]  = req_row(CMD_ACQUIRE, '0, '0, 41'd1, 1'b1, STAT_INVALID);
        dir_tab[3]  = req_row(CMD_RELEASE, '0, '0, '0, 1'b1, STAT_INVALID);
        dir_tab[4]  = req_row(CMD_LOOKUP,  '0, '1, '1, 1'b1, STAT_INVALID);
        dir_tab[5]  = req_row(CMD_UNUSED,  64'd1, '0, 41'd1, 1'b1, STAT_INVALID);
        dir_tab[6]  = req_row(CMD_ACQUIRE, 64'd1, '0, '0, 1'b1, STAT_INVALID);
        dir_tab[7]  = req_row(CMD_ACQUIRE, 64'd1, 40'd1048577, 41'd1, 1'b1, STAT_INVALID);
        dir_tab[8]  = req_row(CMD_ACQUIRE, 64'd1, 40'd1048576, 41'd1, 1'b1, STAT_INVALID);
        dir_tab[9]  = req_row(CMD_ACQUIRE, 64'd1, '0, 41'd1048577, 1'b1, STAT_INVALID);
        dir_tab[10] = req_row(CMD_ACQUIRE, ID_MAX, '1, '1, 1'b1, STAT_INVALID);
        dir_tab[11] = req_row(CMD_ACQUIRE, 64'd1, '0, 41'd1048576, 1'b1, STAT_OK);
        dir_tab[12] = req_row(CMD_ACQUIRE, 64'd1, '0, 41'd1048576, 1'b0, STAT_OK);
        dir_tab[13] = req_row(CMD_ACQUIRE, 64'd2, 40'd1048575, 41'd1, 1'b0, STAT_OK);
        dir_tab[14] = req_row(CMD_ACQUIRE, 64'd1, 40'd100, 41'd10, 1'b0, STAT_OK);
        dir_tab[15] = req_row(CMD_LOOKUP,  64'd1, '1, '1, 1'b0, STAT_OK);
        dir_tab[16] = req_row(CMD_RELEASE, 64'd1, '1, '1, 1'b0, STAT_OK);
        dir_tab[17] = req_row(CMD_LOOKUP,  64'd1, '0, '0, 1'b0, STAT_OK);
        dir_tab[18] = req_row(CMD_ACQUIRE, ID_MAX, 40'd1048575, 41'd1, 1'b0, STAT_OK);
        dir_tab[19] = req_row(CMD_ACQUIRE, 64'd3, '0, 41'd1048575, 1'b0, STAT_OK);
        dir_tab[20] = req_row(CMD_ACQUIRE, 64'd3, '0, 41'd1048576, 1'b0, STAT_OK);
        dir_tab[21] = req_row(CMD_RELEASE, ID_MAX, '0, '0, 1'b0, STAT_OK);
        dir_tab[22] = req_row(CMD_RELEASE, 64'd3, '0, '0, 1'b0, STAT_OK);
        dir_tab[23] = req_row(CMD_LOOKUP,  64'd3, '0, '0, 1'b0, STAT_OK);

        repeat (9)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < DIR_ROWS; i++)
            send_req(dir_tab[i]);
        @(negedge clk);
        in_valid <= 1'b0;
        run_random(330);

        set_region(REGION_MAX);
        run_random(400);

        send_idle = 72;
        recv_idle = 15;
        // shrink with leases still held beyond the new top
        set_region(REGION_MIN);
        run_random(400);

        mid = 64'(REGION_MIN) +
              ({$urandom, $urandom} % (64'(REGION_MAX - REGION_MIN) + 64'd1));
        set_region(mid[LEN_W-1:0]);
        run_random(400);

        send_idle = 0;
        recv_idle = 0;
        set_region(REGION_MAX);
        run_random(400);

        while (expected_status_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);

        $display("Run: %0d requests, %0d statuses checked over five region settings",
                 items_sent, results_checked);
        $display("Expected mix: ok %0d, invalid %0d, conflict %0d, not found %0d, full %0d",
                 stat_tally[0], stat_tally[1], stat_tally[2], stat_tally[3], stat_tally[4]);
        if (fail_count == 0 && expected_status_q.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

### sim.f
rtl/mrlt_pkg.sv
rtl/mrlt_cell.sv
rtl/mrlt_ctrl.sv
rtl/memory_range_lease_table_top.sv
rtl/mrlt_checker.sv
sim/tb_top.sv
